>>> src/tmsplit_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the split table for the tetrahedron mesh splitter.
// No dependencies; imported by every module of the block.
package tmsplit_pkg;

  localparam int TETRA_PER_CELL = 6;
  localparam int CORNERS        = 4;
  localparam int CELL_CORNERS   = 8;
  localparam int QUEUE_DEPTH    = 2;

  // Largest effective grid size per axis; the corner and index widths are sized for it
  localparam int MAX_GRID       = 64;

  localparam int GRID_W   = 7;
  localparam int COORD_W  = 6;
  localparam int CORNER_W = 18;
  localparam int INDEX_W  = 21;
  localparam int SPLIT_W  = 3;

  localparam logic [SPLIT_W-1:0] LAST_SPLIT = SPLIT_W'(TETRA_PER_CELL - 1);

  // Register indexes on the configuration port (byte address = 4 * index)
  localparam logic [2:0] REG_GRID_X   = 3'd0;
  localparam logic [2:0] REG_GRID_Y   = 3'd1;
  localparam logic [2:0] REG_GRID_Z   = 3'd2;
  localparam logic [2:0] REG_MIRROR_X = 3'd3;
  localparam logic [2:0] REG_MIRROR_Y = 3'd4;

  typedef logic [CORNER_W-1:0] corner_t;

  typedef struct packed {
    logic [GRID_W-1:0] gx;
    logic [GRID_W-1:0] gy;
    logic [GRID_W-1:0] gz;
  } grid_cfg_t;

  // One classified cell: the eight wrapped corner indices and the range flag
  typedef struct packed {
    logic                        err;
    corner_t [CELL_CORNERS-1:0]  corner;
  } cell_entry_t;

  // Corner code (bit0 = x, bit1 = y, bit2 = z) of corner j of split i
  function automatic logic [2:0] split_code(logic [SPLIT_W-1:0] split, logic [1:0] j);
    logic [2:0] mid;
    begin
      mid = 3'd0;
      case (split)
        3'd0:    mid = (j == 2'd1) ? 3'd2 : 3'd3;
        3'd1:    mid = (j == 2'd1) ? 3'd1 : 3'd3;
        3'd2:    mid = (j == 2'd1) ? 3'd1 : 3'd5;
        3'd3:    mid = (j == 2'd1) ? 3'd2 : 3'd6;
        3'd4:    mid = (j == 2'd1) ? 3'd4 : 3'd6;
        3'd5:    mid = (j == 2'd1) ? 3'd4 : 3'd5;
        default: mid = 3'd0;
      endcase
      case (j)
        2'd0:    split_code = 3'd0;
        2'd3:    split_code = 3'd7;
        default: split_code = mid;
      endcase
    end
  endfunction

endpackage

>>> src/tmsplit_front.sv
`timescale 1ns / 1ps
// Front pipeline: accepts cells, checks range, wraps and builds the eight corner indices.
// Depends on tmsplit_pkg.
module tmsplit_front import tmsplit_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  grid_cfg_t          grid,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [COORD_W-1:0] cell_x,
  input  logic [COORD_W-1:0] cell_y,
  input  logic [COORD_W-1:0] cell_z,
  output logic               push_valid,
  input  logic               push_stall,
  output cell_entry_t        push_entry
);

  localparam logic [8:0] MAX_GRID_W = 9'(MAX_GRID);

  function automatic logic [GRID_W-1:0] eff_size(logic [GRID_W-1:0] g);
    begin
      if (g == '0) begin
        eff_size = GRID_W'(1);
      end else if ({2'b00, g} > MAX_GRID_W) begin
        eff_size = MAX_GRID_W[GRID_W-1:0];
      end else begin
        eff_size = g;
      end
    end
  endfunction

  function automatic logic [COORD_W-1:0] wrap_next(logic [COORD_W-1:0] c,
                                                   logic [GRID_W-1:0] n);
    logic [GRID_W-1:0] v;
    begin
      v = {1'b0, c} + GRID_W'(1);
      wrap_next = (v >= n) ? '0 : v[COORD_W-1:0];
    end
  endfunction

  logic [GRID_W-1:0] nx, ny, nz;
  logic              en1, en2, en3;

  // stage 1: coordinates and their wrapped neighbors
  logic               v1, err1;
  logic [COORD_W-1:0] x0_1, x1_1, y0_1, y1_1, z0_1, z1_1;
  logic [GRID_W-1:0]  nx_1, ny_1;

  // stage 2: products against the row pitch
  logic               v2, err2;
  logic [COORD_W-1:0] x0_2, x1_2, z0_2, z1_2;
  logic [12:0]        ynx0_2, ynx1_2, nxy_2;

  // stage 3: plane terms
  logic               v3, err3;
  logic [COORD_W-1:0] x0_3, x1_3;
  logic [12:0]        ynx0_3, ynx1_3;
  corner_t            zt0_3, zt1_3;

  assign nx = eff_size(grid.gx);
  assign ny = eff_size(grid.gy);
  assign nz = eff_size(grid.gz);

  assign en3      = !v3 || !push_stall;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_stall = !en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      err1 <= ({1'b0, cell_x} >= nx) || ({1'b0, cell_y} >= ny) || ({1'b0, cell_z} >= nz);
      x0_1 <= cell_x;
      y0_1 <= cell_y;
      z0_1 <= cell_z;
      x1_1 <= wrap_next(cell_x, nx);
      y1_1 <= wrap_next(cell_y, ny);
      z1_1 <= wrap_next(cell_z, nz);
      nx_1 <= nx;
      ny_1 <= ny;
    end
    if (en2) begin
      err2   <= err1;
      x0_2   <= x0_1;
      x1_2   <= x1_1;
      z0_2   <= z0_1;
      z1_2   <= z1_1;
      ynx0_2 <= 13'(y0_1) * 13'(nx_1);
      ynx1_2 <= 13'(y1_1) * 13'(nx_1);
      nxy_2  <= 13'(nx_1) * 13'(ny_1);
    end
    if (en3) begin
      err3   <= err2;
      x0_3   <= x0_2;
      x1_3   <= x1_2;
      ynx0_3 <= ynx0_2;
      ynx1_3 <= ynx1_2;
      zt0_3  <= CORNER_W'(z0_2) * CORNER_W'(nxy_2);
      zt1_3  <= CORNER_W'(z1_2) * CORNER_W'(nxy_2);
    end
  end

  always_comb begin
    push_entry.err = err3;
    for (int c = 0; c < CELL_CORNERS; c++) begin
      push_entry.corner[c] = CORNER_W'(c[0] ? x1_3 : x0_3)
                           + CORNER_W'(c[1] ? ynx1_3 : ynx0_3)
                           + (c[2] ? zt1_3 : zt0_3);
    end
  end

  assign push_valid = v3;

endmodule

>>> src/tmsplit_queue.sv
`timescale 1ns / 1ps
// Short FIFO of classified cells between the front pipeline and the split engine.
// Depends on tmsplit_pkg.
module tmsplit_queue import tmsplit_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push_valid,
  output logic        push_stall,
  input  cell_entry_t push_entry,
  output logic        head_valid,
  input  logic        pop,
  output cell_entry_t head_entry
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cell_entry_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]        wr_ptr, rd_ptr;
  logic [CNT_W-1:0]        count;
  logic                    push;

  assign push_stall = (count == CNT_W'(QUEUE_DEPTH));
  assign push       = push_valid && !push_stall;
  assign head_valid = (count != '0);
  assign head_entry = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_entry;
  end

endmodule

>>> src/tmsplit_back.sv
`timescale 1ns / 1ps
// Split engine: walks the six tetrahedra of the head cell, sorts corners, drives the output beat.
// Depends on tmsplit_pkg.
module tmsplit_back import tmsplit_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                mirror_x,
  input  logic                mirror_y,
  input  logic                head_valid,
  input  cell_entry_t         head_entry,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output corner_t             corner_a,
  output corner_t             corner_b,
  output corner_t             corner_c,
  output corner_t             corner_d,
  output logic [INDEX_W-1:0]  tetra_index,
  output logic                range_error,
  output logic                last_of_cell
);

  logic [SPLIT_W-1:0]  split;
  logic                fire;
  corner_t             t0 [CORNERS];
  corner_t             t1 [CORNERS];
  corner_t             t2 [CORNERS];
  corner_t             t3 [CORNERS];
  logic [2:0]          code;
  logic [INDEX_W-1:0]  base, idx;

  assign fire = head_valid && (!out_valid || !out_stall);
  assign pop  = fire && (split == LAST_SPLIT);

  // Pick the four corners, then a five-exchange sorting network
  always_comb begin
    for (int j = 0; j < CORNERS; j++) begin
      code  = split_code(split, 2'(j)) ^ {1'b0, mirror_y, mirror_x};
      t0[j] = head_entry.corner[code];
    end
    t1 = t0;
    if (t0[0] > t0[1]) begin t1[0] = t0[1]; t1[1] = t0[0]; end
    if (t0[2] > t0[3]) begin t1[2] = t0[3]; t1[3] = t0[2]; end
    t2 = t1;
    if (t1[0] > t1[2]) begin t2[0] = t1[2]; t2[2] = t1[0]; end
    if (t1[1] > t1[3]) begin t2[1] = t1[3]; t2[3] = t1[1]; end
    t3 = t2;
    if (t2[1] > t2[2]) begin t3[1] = t2[2]; t3[2] = t2[1]; end
  end

  // Corner 0 is the cell's own index: index = 6 * cell + split
  assign base = {1'b0, head_entry.corner[0], 2'b00} + {2'b00, head_entry.corner[0], 1'b0};
  assign idx  = base + INDEX_W'(split);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      split     <= '0;
    end else begin
      if (fire) begin
        out_valid <= 1'b1;
        split     <= (split == LAST_SPLIT) ? '0 : split + SPLIT_W'(1);
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      corner_a     <= head_entry.err ? '0 : t3[0];
      corner_b     <= head_entry.err ? '0 : t3[1];
      corner_c     <= head_entry.err ? '0 : t3[2];
      corner_d     <= head_entry.err ? '0 : t3[3];
      tetra_index  <= head_entry.err ? '0 : idx;
      range_error  <= head_entry.err;
      last_of_cell <= (split == LAST_SPLIT);
    end
  end

endmodule

>>> src/tetrahedron_mesh_splitter_core.sv
`timescale 1ns / 1ps
// Top level of the tetrahedron mesh splitter: configuration registers, front, queue, back.
// Depends on tmsplit_pkg, tmsplit_front, tmsplit_queue and tmsplit_back.
//
// Each input beat names one microcell (cell_x, cell_y, cell_z) of a periodic grid of
// grid_x * grid_y * grid_z points. The block returns six output beats per cell, one per
// tetrahedron of the fixed split along the main diagonal, each with its four grid point
// indices x + y*nx + z*nx*ny in ascending order, tetra_index = 6*cell + split number and
// last_of_cell on the sixth beat. mirror_x / mirror_y flip the x / y corner bit of the
// split table. A grid register of 0 acts as 1 and one above MAX_GRID acts as MAX_GRID.
// A coordinate not below its grid size gives six beats with range_error set and all
// indices zero. Rate: the split engine emits one tetrahedron per cycle while a cell is
// queued and out_stall is low; a new cell is accepted every cycle while the three-stage
// front pipeline and the two-entry cell queue have room. Write the configuration only
// while the block is idle.
module tetrahedron_mesh_splitter_core import tmsplit_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  // configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  // cell input
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [COORD_W-1:0]  cell_x,
  input  logic [COORD_W-1:0]  cell_y,
  input  logic [COORD_W-1:0]  cell_z,
  // tetrahedron output
  output logic                out_valid,
  input  logic                out_stall,
  output corner_t             corner_a,
  output corner_t             corner_b,
  output corner_t             corner_c,
  output corner_t             corner_d,
  output logic [INDEX_W-1:0]  tetra_index,
  output logic                range_error,
  output logic                last_of_cell
);

  grid_cfg_t    grid;
  logic         mirror_x, mirror_y;
  logic         cfg_write;
  logic [2:0]   reg_idx;

  logic         push_valid, push_stall, head_valid, pop;
  cell_entry_t  push_entry, head_entry;

  // Configuration registers; pready is tied high so every access completes at once
  assign pready    = 1'b1;
  assign reg_idx   = paddr[4:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid.gx  <= GRID_W'(1);
      grid.gy  <= GRID_W'(1);
      grid.gz  <= GRID_W'(1);
      mirror_x <= 1'b0;
      mirror_y <= 1'b0;
    end else if (cfg_write) begin
      unique case (reg_idx)
        REG_GRID_X:   grid.gx  <= pwdata[GRID_W-1:0];
        REG_GRID_Y:   grid.gy  <= pwdata[GRID_W-1:0];
        REG_GRID_Z:   grid.gz  <= pwdata[GRID_W-1:0];
        REG_MIRROR_X: mirror_x <= pwdata[0];
        REG_MIRROR_Y: mirror_y <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_GRID_X:   prdata = 32'(grid.gx);
      REG_GRID_Y:   prdata = 32'(grid.gy);
      REG_GRID_Z:   prdata = 32'(grid.gz);
      REG_MIRROR_X: prdata = 32'(mirror_x);
      REG_MIRROR_Y: prdata = 32'(mirror_y);
      default:      prdata = '0;
    endcase
  end

  // Front: range check, wrap and corner index arithmetic
  tmsplit_front u_front (
    .clk        (clk),
    .rst        (rst),
    .grid       (grid),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .cell_x     (cell_x),
    .cell_y     (cell_y),
    .cell_z     (cell_z),
    .push_valid (push_valid),
    .push_stall (push_stall),
    .push_entry (push_entry)
  );

  // Hold classified cells while the back works through six beats each
  tmsplit_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_stall (push_stall),
    .push_entry (push_entry),
    .head_valid (head_valid),
    .pop        (pop),
    .head_entry (head_entry)
  );

  // Back: one tetrahedron per cycle into the output register while a cell is queued and out_stall is low
  tmsplit_back u_back (
    .clk          (clk),
    .rst          (rst),
    .mirror_x     (mirror_x),
    .mirror_y     (mirror_y),
    .head_valid   (head_valid),
    .head_entry   (head_entry),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .corner_a     (corner_a),
    .corner_b     (corner_b),
    .corner_c     (corner_c),
    .corner_d     (corner_d),
    .tetra_index  (tetra_index),
    .range_error  (range_error),
    .last_of_cell (last_of_cell)
  );

  // Sorting network leaves the corners ascending
  a_sorted: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (corner_a <= corner_b) && (corner_b <= corner_c) && (corner_c <= corner_d))
    else $error("corners not ascending");

  // An out-of-range cell carries zero indices
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && range_error |-> (corner_a == '0) && (corner_d == '0) && (tetra_index == '0))
    else $error("range error beat with nonzero indices");

  // Within one cell the running index steps by one per beat
  a_index_step: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last_of_cell && !range_error
    |=> !out_valid || (tetra_index == $past(tetra_index) + INDEX_W'(1)))
    else $error("tetra_index did not advance by one");

  // A full queue always has a head entry
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push_stall |-> head_valid)
    else $error("queue full without a head entry");

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for tetrahedron_mesh_splitter_core: APB register setup, cell beats in,
// six tetrahedron beats out per cell. Depends on tmsplit_pkg and the core RTL only.

typedef logic [tmsplit_pkg::INDEX_W-1:0] tindex_t;

typedef struct packed {
  tmsplit_pkg::corner_t a;
  tmsplit_pkg::corner_t b;
  tmsplit_pkg::corner_t c;
  tmsplit_pkg::corner_t d;
  tindex_t              idx;
  logic                 err;
  logic                 last;
} tetra_t;

// Splits each accepted cell into its six expected tetrahedra and matches output beats
class tetra_tracker;
  localparam int GRID_CAP = 64;

  int unsigned grid [3];
  bit          mirror_x;
  bit          mirror_y;
  tetra_t      pending_tetra [$];
  int unsigned bad_tetra;
  bit [2:0]    split_tab [6][4];

  function new();
    grid      = '{1, 1, 1};
    mirror_x  = 1'b0;
    mirror_y  = 1'b0;
    bad_tetra = 0;
    // corner codes: bit0 = x, bit1 = y, bit2 = z; all six share the 0-7 diagonal
    split_tab = '{'{3'd0, 3'd2, 3'd3, 3'd7},
                  '{3'd0, 3'd1, 3'd3, 3'd7},
                  '{3'd0, 3'd1, 3'd5, 3'd7},
                  '{3'd0, 3'd2, 3'd6, 3'd7},
                  '{3'd0, 3'd4, 3'd6, 3'd7},
                  '{3'd0, 3'd4, 3'd5, 3'd7}};
  endfunction

  function int unsigned eff_size(int unsigned g);
    if (g == 0) return 1;
    if (g > GRID_CAP) return GRID_CAP;
    return g;
  endfunction

  function void add_cell(int unsigned x, int unsigned y, int unsigned z);
    int unsigned nx, ny, nz, cell_idx, tmp;
    int unsigned xs [2];
    int unsigned ys [2];
    int unsigned zs [2];
    int unsigned pt [8];
    int unsigned t [4];
    bit          err;
    bit [2:0]    flip;
    tetra_t      want;
    nx    = eff_size(grid[0]);
    ny    = eff_size(grid[1]);
    nz    = eff_size(grid[2]);
    err   = (x >= nx) || (y >= ny) || (z >= nz);
    xs[0] = x; xs[1] = (x + 1 >= nx) ? 0 : x + 1;
    ys[0] = y; ys[1] = (y + 1 >= ny) ? 0 : y + 1;
    zs[0] = z; zs[1] = (z + 1 >= nz) ? 0 : z + 1;
    for (int c = 0; c < 8; c++)
      pt[c] = xs[c & 1] + ys[(c >> 1) & 1] * nx + zs[(c >> 2) & 1] * nx * ny;
    cell_idx = x + y * nx + z * nx * ny;
    flip = {1'b0, mirror_y, mirror_x};
    for (int i = 0; i < 6; i++) begin
      for (int j = 0; j < 4; j++)
        t[j] = err ? 0 : pt[split_tab[i][j] ^ flip];
      // four values: a plain exchange sort is enough
      for (int p = 0; p < 3; p++)
        for (int q = 0; q < 3 - p; q++)
          if (t[q] > t[q+1]) begin
            tmp = t[q]; t[q] = t[q+1]; t[q+1] = tmp;
          end
      want.a    = tmsplit_pkg::corner_t'(t[0]);
      want.b    = tmsplit_pkg::corner_t'(t[1]);
      want.c    = tmsplit_pkg::corner_t'(t[2]);
      want.d    = tmsplit_pkg::corner_t'(t[3]);
      want.idx  = err ? '0 : tindex_t'(cell_idx * 6 + i);
      want.err  = err;
      want.last = (i == 5);
      pending_tetra = {pending_tetra, want};
    end
  endfunction

  function void check_tetra(tetra_t got);
    tetra_t want;
    if (pending_tetra.size() == 0) begin
      bad_tetra++;
      if (bad_tetra <= 10)
        $display("[%0t] unexpected beat: a=%0d b=%0d c=%0d d=%0d idx=%0d err=%0b last=%0b",
                 $time, got.a, got.b, got.c, got.d, got.idx, got.err, got.last);
      return;
    end
    want = pending_tetra.pop_front();
    if (got.a !== want.a || got.b !== want.b || got.c !== want.c || got.d !== want.d ||
        got.idx !== want.idx || got.err !== want.err || got.last !== want.last) begin
      bad_tetra++;
      if (bad_tetra <= 10) begin
        $display("[%0t] exp: a=%0d b=%0d c=%0d d=%0d idx=%0d err=%0b last=%0b", $time,
                 want.a, want.b, want.c, want.d, want.idx, want.err, want.last);
        $display("[%0t] got: a=%0d b=%0d c=%0d d=%0d idx=%0d err=%0b last=%0b", $time,
                 got.a, got.b, got.c, got.d, got.idx, got.err, got.last);
      end
    end
  endfunction
endclass

module tb_top;
  import tmsplit_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 8;   // margin after the last expected beat

  logic                clk;
  logic                rst     = 1'b1;
  logic                psel    = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite  = 1'b0;
  logic [4:0]          paddr   = '0;
  logic [31:0]         pwdata  = '0;
  logic [31:0]         prdata;
  logic                pready;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [COORD_W-1:0]  cell_x = '0;
  logic [COORD_W-1:0]  cell_y = '0;
  logic [COORD_W-1:0]  cell_z = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  corner_t             corner_a, corner_b, corner_c, corner_d;
  logic [INDEX_W-1:0]  tetra_index;
  logic                range_error;
  logic                last_of_cell;

  // per-phase switches: off gives stretches with no idling on that side
  bit          tx_gap_on = 1'b1;
  bit          rx_pause_on = 1'b1;
  int unsigned cycle_count = 0;

  tetra_tracker tracker = new();

  tetrahedron_mesh_splitter_core DUT (
    .clk, .rst,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid, .in_stall, .cell_x, .cell_y, .cell_z,
    .out_valid, .out_stall,
    .corner_a, .corner_b, .corner_c, .corner_d,
    .tetra_index, .range_error, .last_of_cell
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop: slowest legal run is far below this
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tetrahedron_mesh_splitter_core: mismatch");
      $finish;
    end
  end

  // Receiver: draw a pause before each output beat, then take the beat
  initial begin
    int unsigned pause;
    @(posedge clk);
    forever begin
      pause = rx_pause_on ? $urandom_range(0, 5) : 0;
      if (pause > 0) begin
        out_stall <= 1'b1;
        repeat (pause) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (rst || out_valid !== 1'b1 || out_stall);
    end
  end

  // Monitor: sample pre-edge values, so the check never races the block's own updates
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && !out_stall)
      tracker.check_tetra('{corner_a, corner_b, corner_c, corner_d,
                            tetra_index, range_error, last_of_cell});
  end

  // APB write with setup and access phases; hold until pready on the access cycle
  task automatic write_reg(logic [2:0] idx, int unsigned value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_GRID_X:   tracker.grid[0]  = value & 32'h7F;
      REG_GRID_Y:   tracker.grid[1]  = value & 32'h7F;
      REG_GRID_Z:   tracker.grid[2]  = value & 32'h7F;
      REG_MIRROR_X: tracker.mirror_x = value[0];
      REG_MIRROR_Y: tracker.mirror_y = value[0];
      default: ;
    endcase
  endtask

  task automatic set_grid(int unsigned gx, int unsigned gy, int unsigned gz,
                          bit mx, bit my);
    write_reg(REG_GRID_X, gx);
    write_reg(REG_GRID_Y, gy);
    write_reg(REG_GRID_Z, gz);
    write_reg(REG_MIRROR_X, 32'(mx));
    write_reg(REG_MIRROR_Y, 32'(my));
  endtask

  // Present one cell beat after a random gap; hold it until accepted
  task automatic send_cell(int unsigned x, int unsigned y, int unsigned z);
    int unsigned gap;
    gap = tx_gap_on ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cell_x   <= COORD_W'(x);
    cell_y   <= COORD_W'(y);
    cell_z   <= COORD_W'(z);
    do @(posedge clk); while (in_stall !== 1'b0);
    tracker.add_cell(x, y, z);
  endtask

  // Drop valid, let every expected tetrahedron arrive, then cover the pipeline tail
  task automatic drain;
    in_valid <= 1'b0;
    while (tracker.pending_tetra.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic random_phase(int n);
    int unsigned g [3];
    int unsigned lim [3];
    int unsigned pick;
    for (int k = 0; k < 3; k++) begin
      pick = $urandom_range(0, 9);
      if (pick == 0)      g[k] = 0;                         // acts as one point
      else if (pick == 1) g[k] = $urandom_range(65, 127);   // clamps to the cap
      else if (pick == 2) g[k] = 64;
      else                g[k] = $urandom_range(1, 64);
      lim[k] = tracker.eff_size(g[k]) - 1;
    end
    set_grid(g[0], g[1], g[2], 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    tx_gap_on   = ($urandom_range(0, 3) != 0);
    rx_pause_on = ($urandom_range(0, 3) != 0);
    for (int i = 0; i < n; i++) begin
      // mostly cells inside the grid; the rest anywhere, which hits the range check
      if ($urandom_range(0, 6) == 0)
        send_cell($urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 63));
      else
        send_cell($urandom_range(0, lim[0]), $urandom_range(0, lim[1]),
                  $urandom_range(0, lim[2]));
    end
    drain();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset grid is a single point: only the origin is in range
    send_cell(0, 0, 0);
    send_cell(1, 0, 0);
    send_cell(0, 63, 0);
    send_cell(63, 63, 63);
    drain();

    // Full grid, no mirroring: coordinate extremes and alternating bit patterns
    set_grid(64, 64, 64, 1'b0, 1'b0);
    send_cell(0, 0, 0);
    send_cell(63, 63, 63);
    send_cell(63, 0, 0);
    send_cell(0, 63, 0);
    send_cell(0, 0, 63);
    send_cell(42, 21, 42);
    send_cell(21, 42, 21);
    drain();

    // The other three mirroring combinations, with wrap on the top cell
    set_grid(64, 64, 64, 1'b1, 1'b0);
    send_cell(63, 63, 63);
    send_cell(5, 9, 13);
    drain();
    set_grid(64, 64, 64, 1'b0, 1'b1);
    send_cell(63, 63, 63);
    send_cell(5, 9, 13);
    drain();
    set_grid(3, 2, 5, 1'b1, 1'b1);
    send_cell(2, 1, 4);
    send_cell(2, 2, 4);
    send_cell(0, 0, 5);
    drain();

    // Zero grid acts as one point, oversize grids clamp to the cap
    set_grid(0, 127, 65, 1'b1, 1'b0);
    send_cell(0, 63, 63);
    send_cell(1, 0, 0);
    send_cell(0, 31, 62);
    send_cell(0, 63, 0);
    drain();

    for (int ph = 0; ph < 8; ph++)
      random_phase(30);

    tx_gap_on   = 1'b1;
    rx_pause_on = 1'b1;
    drain();

    if (tracker.bad_tetra == 0)
      $display("tetrahedron_mesh_splitter_core: match");
    else
      $display("tetrahedron_mesh_splitter_core: mismatch");
    $finish;
  end

endmodule

>>> sim.f
src/tmsplit_pkg.sv
src/tmsplit_front.sv
src/tmsplit_queue.sv
src/tmsplit_back.sv
src/tetrahedron_mesh_splitter_core.sv
dv/tb_top.sv
